// ===== hw/rtl/mshw_pkg.sv =====
// Package for the multi-sensor heartbeat watchdog: register indexes, codes and reset values.
package mshw_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_IDX_WIDTH = 3;

    typedef logic [CFG_WIDTH-1:0]     t_cfg;
    typedef logic [CFG_IDX_WIDTH-1:0] t_cfg_idx;
    typedef logic [1:0]               t_status;
    typedef logic [1:0]               t_sensor;

    localparam t_cfg_idx REG_IMU_TIMEOUT     = 3'd0;
    localparam t_cfg_idx REG_LIDAR_TIMEOUT   = 3'd1;
    localparam t_cfg_idx REG_MOTOR_TIMEOUT   = 3'd2;
    localparam t_cfg_idx REG_GRACE_PERIOD    = 3'd3;
    localparam t_cfg_idx REG_DEBOUNCE_PERIOD = 3'd4;

    localparam t_cfg RST_IMU_TIMEOUT     = 16'd500;
    localparam t_cfg RST_LIDAR_TIMEOUT   = 16'd500;
    localparam t_cfg RST_MOTOR_TIMEOUT   = 16'd1000;
    localparam t_cfg RST_GRACE_PERIOD    = 16'd3000;
    localparam t_cfg RST_DEBOUNCE_PERIOD = 16'd300;

    localparam t_status STATUS_GRACE    = 2'd0;
    localparam t_status STATUS_OK       = 2'd1;
    localparam t_status STATUS_DEBOUNCE = 2'd2;
    localparam t_status STATUS_FAIL     = 2'd3;

    localparam t_sensor SENSOR_IMU   = 2'd0;
    localparam t_sensor SENSOR_LIDAR = 2'd1;
    localparam t_sensor SENSOR_MOTOR = 2'd2;

endpackage

// ===== hw/rtl/multi_sensor_heartbeat_watchdog.sv =====
// Heartbeat watchdog for three sensors with startup grace and failure debounce.
//
// Input channel (i_in_valid / o_in_ready): one word per millisecond tick with the
// IMU, lidar and motor heartbeat flags and a report strobe.
// Output channel (o_out_valid / i_out_ready): one report word for each tick whose
// report strobe is set: system_ok, status_code and failed_sensor.
// Config channel (i_cfg_valid / o_cfg_ready): register index and data; always ready.
// Unknown indexes are ignored. Write only while the block is idle.
// Counters and the debounce state update in the cycle a tick word is accepted,
// and the report is registered in that same edge.
// Throughput is one tick per cycle while no report is stalled in the single output register.
// o_in_ready is high while the output register is empty or being drained, so a
// stalled receiver holds the pending report and blocks only further ticks.
// Synchronous reset restores the register defaults, clears all age, uptime and
// debounce state and empties the output register.
module multi_sensor_heartbeat_watchdog #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_imu_seen,
    input  logic                     i_lidar_seen,
    input  logic                     i_motor_seen,
    input  logic                     i_report_now,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_system_ok,
    output logic [1:0]               o_status_code,
    output logic [1:0]               o_failed_sensor,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mshw_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [mshw_pkg::CFG_WIDTH-1:0]     i_cfg_data
);

    localparam int CMP_W = (TIME_WIDTH > mshw_pkg::CFG_WIDTH) ? TIME_WIDTH : mshw_pkg::CFG_WIDTH;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [CMP_W-1:0]      t_cmp;

    mshw_pkg::t_cfg r_imu_timeout, r_lidar_timeout, r_motor_timeout;
    mshw_pkg::t_cfg r_grace_period, r_debounce_period;

    t_time r_imu_age, r_lidar_age, r_motor_age, r_uptime, r_fail_age;
    logic  r_failing;

    t_time n_imu_age, n_lidar_age, n_motor_age, n_uptime, n_fail_age;
    logic  n_failing;

    logic              r_out_valid;
    logic              r_system_ok, n_system_ok;
    mshw_pkg::t_status r_status_code, n_status_code;
    mshw_pkg::t_sensor r_failed_sensor, n_failed_sensor;

    logic in_accept;
    logic in_grace;
    logic imu_to, lidar_to, motor_to, any_fail;
    t_time fail_age_inc;

    function automatic t_time sat_inc(input t_time v);
        return (v == '1) ? v : t_time'(v + 1'b1);
    endfunction

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_uptime     = sat_inc(r_uptime);
        n_imu_age    = i_imu_seen   ? '0 : sat_inc(r_imu_age);
        n_lidar_age  = i_lidar_seen ? '0 : sat_inc(r_lidar_age);
        n_motor_age  = i_motor_seen ? '0 : sat_inc(r_motor_age);
        fail_age_inc = r_failing ? sat_inc(r_fail_age) : r_fail_age;

        in_grace = t_cmp'(n_uptime) < t_cmp'(r_grace_period);
        imu_to   = t_cmp'(n_imu_age)   > t_cmp'(r_imu_timeout);
        lidar_to = t_cmp'(n_lidar_age) > t_cmp'(r_lidar_timeout);
        motor_to = t_cmp'(n_motor_age) > t_cmp'(r_motor_timeout);
        any_fail = imu_to || lidar_to || motor_to;

        if (imu_to) begin
            n_failed_sensor = mshw_pkg::SENSOR_IMU;
        end else if (lidar_to) begin
            n_failed_sensor = mshw_pkg::SENSOR_LIDAR;
        end else if (motor_to) begin
            n_failed_sensor = mshw_pkg::SENSOR_MOTOR;
        end else begin
            n_failed_sensor = mshw_pkg::SENSOR_IMU;
        end

        n_failing     = r_failing;
        n_fail_age    = fail_age_inc;
        n_system_ok   = 1'b1;
        n_status_code = mshw_pkg::STATUS_GRACE;

        if (i_report_now) begin
            if (in_grace) begin
                n_failed_sensor = mshw_pkg::SENSOR_IMU;
            end else if (!any_fail) begin
                n_failing     = 1'b0;
                n_fail_age    = '0;
                n_status_code = mshw_pkg::STATUS_OK;
            end else begin
                n_failing = 1'b1;
                if (!r_failing) begin
                    n_fail_age = '0;
                end
                if (t_cmp'(n_fail_age) >= t_cmp'(r_debounce_period)) begin
                    n_system_ok   = 1'b0;
                    n_status_code = mshw_pkg::STATUS_FAIL;
                end else begin
                    n_status_code = mshw_pkg::STATUS_DEBOUNCE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_timeout     <= mshw_pkg::RST_IMU_TIMEOUT;
            r_lidar_timeout   <= mshw_pkg::RST_LIDAR_TIMEOUT;
            r_motor_timeout   <= mshw_pkg::RST_MOTOR_TIMEOUT;
            r_grace_period    <= mshw_pkg::RST_GRACE_PERIOD;
            r_debounce_period <= mshw_pkg::RST_DEBOUNCE_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mshw_pkg::REG_IMU_TIMEOUT:     r_imu_timeout     <= i_cfg_data;
                mshw_pkg::REG_LIDAR_TIMEOUT:   r_lidar_timeout   <= i_cfg_data;
                mshw_pkg::REG_MOTOR_TIMEOUT:   r_motor_timeout   <= i_cfg_data;
                mshw_pkg::REG_GRACE_PERIOD:    r_grace_period    <= i_cfg_data;
                mshw_pkg::REG_DEBOUNCE_PERIOD: r_debounce_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_age   <= '0;
            r_lidar_age <= '0;
            r_motor_age <= '0;
            r_uptime    <= '0;
            r_fail_age  <= '0;
            r_failing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_imu_age   <= n_imu_age;
                r_lidar_age <= n_lidar_age;
                r_motor_age <= n_motor_age;
                r_uptime    <= n_uptime;
                r_fail_age  <= n_fail_age;
                r_failing   <= n_failing;
            end
            if (in_accept && i_report_now) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_report_now) begin
            r_system_ok     <= n_system_ok;
            r_status_code   <= n_status_code;
            r_failed_sensor <= n_failed_sensor;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_system_ok     = r_system_ok;
    assign o_status_code   = r_status_code;
    assign o_failed_sensor = r_failed_sensor;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multi-sensor heartbeat watchdog: driver, monitor and predictor.
module tb_top;

    localparam int AGE_W = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES = 14;
    localparam int SOAK_TICKS = 160;
    localparam longint LIMIT_NS = 2_000_000;

    typedef logic [AGE_W-1:0] t_age;
    typedef struct packed {
        logic imu;
        logic lidar;
        logic motor;
        logic report;
    } t_tick;
    typedef struct packed {
        logic              ok;
        mshw_pkg::t_status status;
        mshw_pkg::t_sensor sensor;
    } t_report;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_tick              tick_bus = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    mshw_pkg::t_cfg_idx cfg_index = '0;
    mshw_pkg::t_cfg     cfg_data = '0;
    logic               in_ready;
    logic               out_valid;
    logic               system_ok;
    logic [1:0]         status_code;
    logic [1:0]         failed_sensor;
    logic               cfg_ready;

    t_tick       pending_ticks[$];
    t_report     expected_reports[$];
    bit          idle_en = 1'b1;
    int          in_gap = 0;
    int          stall_left = 0;
    int unsigned n_fail = 0;

    // shadow registers and watchdog state
    mshw_pkg::t_cfg imu_limit, lidar_limit, motor_limit, grace_len, debounce_len;
    t_age imu_age, lidar_age, motor_age, uptime, fail_age;
    logic failing;

    always #1 clk = ~clk;

    multi_sensor_heartbeat_watchdog #(.TIME_WIDTH(AGE_W)) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_imu_seen      (tick_bus.imu),
        .i_lidar_seen    (tick_bus.lidar),
        .i_motor_seen    (tick_bus.motor),
        .i_report_now    (tick_bus.report),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_system_ok     (system_ok),
        .o_status_code   (status_code),
        .o_failed_sensor (failed_sensor),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    function automatic t_age bump(t_age v);
        return (&v) ? v : t_age'(v + 1'b1);
    endfunction

    function automatic void advance_watchdog(t_tick t);
        t_report           r;
        logic              late;
        mshw_pkg::t_sensor who;
        uptime = bump(uptime);
        imu_age = t.imu ? '0 : bump(imu_age);
        lidar_age = t.lidar ? '0 : bump(lidar_age);
        motor_age = t.motor ? '0 : bump(motor_age);
        if (failing)
            fail_age = bump(fail_age);
        if (t.report) begin
            late = 1'b1;
            who = mshw_pkg::SENSOR_IMU;
            if (imu_age > imu_limit)
                who = mshw_pkg::SENSOR_IMU;
            else if (lidar_age > lidar_limit)
                who = mshw_pkg::SENSOR_LIDAR;
            else if (motor_age > motor_limit)
                who = mshw_pkg::SENSOR_MOTOR;
            else
                late = 1'b0;
            if (uptime < grace_len) begin
                r = '{1'b1, mshw_pkg::STATUS_GRACE, mshw_pkg::SENSOR_IMU};
            end else if (!late) begin
                failing = 1'b0;
                fail_age = '0;
                r = '{1'b1, mshw_pkg::STATUS_OK, mshw_pkg::SENSOR_IMU};
            end else begin
                if (!failing) begin
                    failing = 1'b1;
                    fail_age = '0;
                end
                r.ok = (fail_age < debounce_len);
                r.status = r.ok ? mshw_pkg::STATUS_DEBOUNCE : mshw_pkg::STATUS_FAIL;
                r.sensor = who;
            end
            expected_reports.push_back(r);
        end
    endfunction

    function automatic mshw_pkg::t_cfg pick_timeout();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return mshw_pkg::t_cfg'($urandom);
            default: return mshw_pkg::t_cfg'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic void push_tick(logic imu, logic lidar, logic motor, logic report);
        pending_ticks.push_back('{imu, lidar, motor, report});
    endfunction

    task automatic settle();
        while (pending_ticks.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(mshw_pkg::t_cfg_idx idx, mshw_pkg::t_cfg val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // tick driver and predictor update
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
            imu_limit = mshw_pkg::RST_IMU_TIMEOUT;
            lidar_limit = mshw_pkg::RST_LIDAR_TIMEOUT;
            motor_limit = mshw_pkg::RST_MOTOR_TIMEOUT;
            grace_len = mshw_pkg::RST_GRACE_PERIOD;
            debounce_len = mshw_pkg::RST_DEBOUNCE_PERIOD;
            imu_age = '0;
            lidar_age = '0;
            motor_age = '0;
            uptime = '0;
            fail_age = '0;
            failing = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mshw_pkg::REG_IMU_TIMEOUT:     imu_limit = cfg_data;
                    mshw_pkg::REG_LIDAR_TIMEOUT:   lidar_limit = cfg_data;
                    mshw_pkg::REG_MOTOR_TIMEOUT:   motor_limit = cfg_data;
                    mshw_pkg::REG_GRACE_PERIOD:    grace_len = cfg_data;
                    mshw_pkg::REG_DEBOUNCE_PERIOD: debounce_len = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                advance_watchdog(tick_bus);
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    tick_bus <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // report monitor and receiver stalls
    always @(posedge clk) begin : report_check
        t_report want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report word with none expected: ok=%0d status=%0d sensor=%0d",
                           system_ok, status_code, failed_sensor);
                    n_fail++;
                end else begin
                    want = expected_reports.pop_front();
                    if (system_ok !== want.ok) begin
                        $error("system_ok: expected %0d, got %0d", want.ok, system_ok);
                        n_fail++;
                    end
                    if (status_code !== want.status) begin
                        $error("status_code: expected %0d, got %0d", want.status, status_code);
                        n_fail++;
                    end
                    if (failed_sensor !== want.sensor) begin
                        $error("failed_sensor: expected %0d, got %0d", want.sensor,
                               failed_sensor);
                        n_fail++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int    hb [3];
        int    rp;
        int    n_ticks;
        t_tick t;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: startup grace
        push_tick(1'b1, 1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0, 1'b0);
        settle();

        // tight limits: each sensor times out, debounce, hard fail, recovery
        write_reg(mshw_pkg::REG_IMU_TIMEOUT, 16'd0);
        write_reg(mshw_pkg::REG_LIDAR_TIMEOUT, 16'd1);
        write_reg(mshw_pkg::REG_MOTOR_TIMEOUT, 16'd2);
        write_reg(mshw_pkg::REG_GRACE_PERIOD, 16'd0);
        write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, 16'd2);
        push_tick(1'b1, 1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        settle();

        // zero debounce: hard fail on the first failing report
        write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, 16'd0);
        push_tick(1'b1, 1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1, 1'b1);
        settle();

        write_reg(mshw_pkg::REG_GRACE_PERIOD, 16'hFFFF);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_en = (p < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                write_reg(mshw_pkg::t_cfg_idx'($urandom_range(
                              mshw_pkg::REG_DEBOUNCE_PERIOD + 1,
                              (1 << mshw_pkg::CFG_IDX_WIDTH) - 1)),
                          mshw_pkg::t_cfg'($urandom));
            write_reg(mshw_pkg::REG_IMU_TIMEOUT, pick_timeout());
            write_reg(mshw_pkg::REG_LIDAR_TIMEOUT, pick_timeout());
            write_reg(mshw_pkg::REG_MOTOR_TIMEOUT, pick_timeout());
            case ($urandom_range(0, 7))
                0: write_reg(mshw_pkg::REG_GRACE_PERIOD,
                             mshw_pkg::t_cfg'(uptime + $urandom_range(0, 40)));
                1: write_reg(mshw_pkg::REG_GRACE_PERIOD, '1);
                2: write_reg(mshw_pkg::REG_GRACE_PERIOD, mshw_pkg::t_cfg'($urandom));
                default: write_reg(mshw_pkg::REG_GRACE_PERIOD,
                                   mshw_pkg::t_cfg'($urandom_range(0, int'(uptime))));
            endcase
            case ($urandom_range(0, 9))
                0: write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, '0);
                1: write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, '1);
                2: write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, mshw_pkg::t_cfg'($urandom));
                default: write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD,
                                   mshw_pkg::t_cfg'($urandom_range(1, 10)));
            endcase
            for (int s = 0; s < 3; s++) begin
                case ($urandom_range(0, 5))
                    0: hb[s] = 0;
                    1: hb[s] = 1;
                    default: hb[s] = 1 << $urandom_range(1, 4);
                endcase
            end
            rp = $urandom_range(1, 3);
            n_ticks = $urandom_range(85, 110);
            for (int k = 0; k < n_ticks; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    t = t_tick'($urandom);
                end else begin
                    t.imu = (hb[0] != 0) && ($urandom_range(0, hb[0] - 1) == 0);
                    t.lidar = (hb[1] != 0) && ($urandom_range(0, hb[1] - 1) == 0);
                    t.motor = (hb[2] != 0) && ($urandom_range(0, hb[2] - 1) == 0);
                    t.report = ($urandom_range(0, rp - 1) == 0);
                end
                pending_ticks.push_back(t);
            end
            settle();
        end

        // long silence: the motor age runs far past its limit while debouncing
        idle_en = 1'b0;
        write_reg(mshw_pkg::REG_IMU_TIMEOUT, '1);
        write_reg(mshw_pkg::REG_LIDAR_TIMEOUT, '1);
        write_reg(mshw_pkg::REG_MOTOR_TIMEOUT, '0);
        write_reg(mshw_pkg::REG_GRACE_PERIOD, '0);
        write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, '1);
        for (int k = 0; k < SOAK_TICKS; k++)
            push_tick(1'b0, 1'b0, 1'b0, (k % 32 == 0) || (k >= SOAK_TICKS - 3));
        settle();

        write_reg(mshw_pkg::REG_MOTOR_TIMEOUT, '1);
        write_reg(mshw_pkg::REG_GRACE_PERIOD, '1);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        settle();
        write_reg(mshw_pkg::REG_LIDAR_TIMEOUT, 16'hFFFE);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        settle();
        write_reg(mshw_pkg::REG_DEBOUNCE_PERIOD, '0);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        settle();
        write_reg(mshw_pkg::REG_IMU_TIMEOUT, 16'hFFFE);
        push_tick(1'b0, 1'b0, 1'b0, 1'b1);
        settle();

        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mshw_pkg.sv
hw/rtl/multi_sensor_heartbeat_watchdog.sv
dv/tb_top.sv
